>>> design/biou_pkg.sv
`default_nettype none

package biou_pkg;

    // Field and arithmetic widths.
    localparam int COORD_W     = 16;
    localparam int FRAC_W      = 12;
    localparam int HALF_SHIFT  = FRAC_W - 1;
    localparam int GRID_W      = 7;
    localparam int BOX_IDX_W   = 3;
    localparam int BOXES_PER_CELL = 2;
    localparam int IOU_W       = 16;
    localparam int IOU_FRAC    = 15;
    localparam logic [IOU_W-1:0] IOU_ONE = IOU_W'(1 << IOU_FRAC);

    // Center division: the dividend is |c| << FRAC_W, retired four bits a cycle.
    localparam int DVD_W       = COORD_W + FRAC_W;
    localparam int DIV_RADIX_BITS = 4;
    localparam int DIV_CYCLES  = DVD_W / DIV_RADIX_BITS;
    localparam int LANES       = 4;

    // Corners, spans, areas and union.
    localparam int CORNER_W    = DVD_W + 2;
    localparam int EXT_W       = CORNER_W + 1;
    localparam int SPAN_W      = CORNER_W;
    localparam int INTER_W     = 2 * SPAN_W;
    localparam int AREA_W      = 2 * COORD_W;
    localparam int AREA_SUM_W  = AREA_W + 1;
    localparam int AREA_SHIFT  = 2 * FRAC_W;
    localparam int UNI_W       = INTER_W + 2;

    localparam int CNT_W       = 4;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int IN_DATA_W   = 8 * COORD_W;
    localparam int OUT_FIELDS_W = 2 * IOU_W + BOX_IDX_W;
    localparam int OUT_DATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef struct packed {
        logic signed [COORD_W-1:0] pred_cx;
        logic signed [COORD_W-1:0] pred_cy;
        logic signed [COORD_W-1:0] pred_w;
        logic signed [COORD_W-1:0] pred_h;
        logic signed [COORD_W-1:0] tgt_cx;
        logic signed [COORD_W-1:0] tgt_cy;
        logic signed [COORD_W-1:0] tgt_w;
        logic signed [COORD_W-1:0] tgt_h;
        logic [BOX_IDX_W-1:0]      idx;
        logic                      done;
    } biou_item_t;

    function automatic logic signed [CORNER_W-1:0] half_size(
        input logic signed [COORD_W-1:0] s
    );
        return $signed({{(CORNER_W-COORD_W-HALF_SHIFT){s[COORD_W-1]}}, s,
                        {HALF_SHIFT{1'b0}}});
    endfunction

    function automatic logic signed [CORNER_W-1:0] center(
        input logic [DVD_W-1:0] q,
        input logic             neg
    );
        logic signed [CORNER_W-1:0] m;
        m = $signed({{(CORNER_W-DVD_W){1'b0}}, q});
        return neg ? -m : m;
    endfunction

    // Overlap along one axis, clamped at zero.
    function automatic logic [SPAN_W-1:0] overlap(
        input logic signed [CORNER_W-1:0] c_p,
        input logic signed [COORD_W-1:0]  s_p,
        input logic signed [CORNER_W-1:0] c_t,
        input logic signed [COORD_W-1:0]  s_t
    );
        logic signed [CORNER_W-1:0] lo_p;
        logic signed [CORNER_W-1:0] hi_p;
        logic signed [CORNER_W-1:0] lo_t;
        logic signed [CORNER_W-1:0] hi_t;
        logic signed [CORNER_W-1:0] mn;
        logic signed [CORNER_W-1:0] mx;
        logic [EXT_W-1:0]           d;
        lo_p = c_p - half_size(s_p);
        hi_p = c_p + half_size(s_p);
        lo_t = c_t - half_size(s_t);
        hi_t = c_t + half_size(s_t);
        mn = (hi_p < hi_t) ? hi_p : hi_t;
        mx = (lo_p > lo_t) ? lo_p : lo_t;
        d = {mn[CORNER_W-1], mn} - {mx[CORNER_W-1], mx};
        return d[EXT_W-1] ? '0 : d[SPAN_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> design/biou_front.sv
`default_nettype none

module biou_front (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               s_tvalid,
    output logic                              s_tready,
    input  wire  [biou_pkg::IN_DATA_W-1:0]    s_tdata,
    input  wire                               s_tlast,
    input  wire                               q_full,
    output logic                              push,
    output biou_pkg::biou_item_t              push_item
);
    import biou_pkg::*;

    logic [BOX_IDX_W-1:0] box_position_reg;
    logic [BOX_IDX_W-1:0] box_position_next;
    logic                 done;

    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;

    // A cell ends on the last flag or when its box slots are used up.
    assign done = s_tlast || (box_position_reg >= BOX_IDX_W'(BOXES_PER_CELL - 1));

    always_comb
    begin
        push_item.pred_cx = $signed(s_tdata[0*COORD_W +: COORD_W]);
        push_item.pred_cy = $signed(s_tdata[1*COORD_W +: COORD_W]);
        push_item.pred_w  = $signed(s_tdata[2*COORD_W +: COORD_W]);
        push_item.pred_h  = $signed(s_tdata[3*COORD_W +: COORD_W]);
        push_item.tgt_cx  = $signed(s_tdata[4*COORD_W +: COORD_W]);
        push_item.tgt_cy  = $signed(s_tdata[5*COORD_W +: COORD_W]);
        push_item.tgt_w   = $signed(s_tdata[6*COORD_W +: COORD_W]);
        push_item.tgt_h   = $signed(s_tdata[7*COORD_W +: COORD_W]);
        push_item.idx     = box_position_reg;
        push_item.done    = done;
    end

    assign box_position_next = done ? '0 : box_position_reg + BOX_IDX_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_position_reg <= '0;
        end
        else if (push)
        begin
            box_position_reg <= box_position_next;
        end
    end

endmodule

`default_nettype wire

>>> design/biou_fifo.sv
`default_nettype none

module biou_fifo (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  push,
    input  wire biou_pkg::biou_item_t push_item,
    output logic                 full,
    input  wire                  pop,
    output logic                 not_empty,
    output biou_pkg::biou_item_t rd_item
);
    import biou_pkg::*;

    biou_item_t           entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]    wptr_reg;
    logic [QPTR_W-1:0]    rptr_reg;
    logic [QCNT_W-1:0]    count_reg;
    logic                 do_pop;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_pop    = pop && not_empty;
    assign rd_item   = entry_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            entry_reg[wptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wptr_reg <= (wptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rptr_reg <= (rptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rptr_reg + QPTR_W'(1);
            end
            if ((push && !full) && !do_pop)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (!(push && !full) && do_pop)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

>>> design/biou_back.sv
`default_nettype none

module biou_back (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire  [biou_pkg::GRID_W-1:0]       grid_count,
    input  wire                               item_valid,
    input  wire  biou_pkg::biou_item_t        item,
    output logic                              item_pop,
    output logic                              m_tvalid,
    input  wire                               m_tready,
    output logic [biou_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic                              m_tuser,
    output logic                              m_tlast
);
    import biou_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CDIV  = 3'd1;
    localparam logic [2:0] ST_CORN  = 3'd2;
    localparam logic [2:0] ST_MUL   = 3'd3;
    localparam logic [2:0] ST_UNI   = 3'd4;
    localparam logic [2:0] ST_CHK   = 3'd5;
    localparam logic [2:0] ST_RATIO = 3'd6;
    localparam logic [2:0] ST_OUT   = 3'd7;

    logic [2:0]                     state_reg;
    logic [CNT_W-1:0]               cnt_reg;
    biou_item_t                     item_reg;
    logic [GRID_W-1:0]              div_reg;

    logic [LANES-1:0][DVD_W-1:0]    dvd_reg;
    logic [LANES-1:0][DVD_W-1:0]    dvd_next;
    logic [LANES-1:0][GRID_W-1:0]   rem_reg;
    logic [LANES-1:0][GRID_W-1:0]   rem_next;
    logic [LANES-1:0]               neg_reg;

    logic [SPAN_W-1:0]              iw_reg;
    logic [SPAN_W-1:0]              ih_reg;
    logic [SPAN_W-1:0]              iw_next;
    logic [SPAN_W-1:0]              ih_next;
    logic signed [AREA_W-1:0]       area_p_reg;
    logic signed [AREA_W-1:0]       area_t_reg;
    logic [INTER_W-1:0]             inter_reg;
    logic signed [UNI_W-1:0]        uni_reg;
    logic [UNI_W-1:0]               part_reg;
    logic [UNI_W-1:0]               part_shift;
    logic [IOU_FRAC-1:0]            quo_reg;
    logic [IOU_W-1:0]               iou_reg;
    logic                           degen_reg;

    logic [IOU_W-1:0]               best_iou_reg;
    logic [BOX_IDX_W-1:0]           best_index_reg;
    logic                           better;
    logic [IOU_W-1:0]               new_best_iou;
    logic [BOX_IDX_W-1:0]           new_best_index;
    logic signed [AREA_SUM_W-1:0]   area_sum;
    logic [UNI_W-1:0]               inter_ext;
    logic                           out_free;

    logic                           m_tvalid_reg;
    logic [OUT_DATA_W-1:0]          m_tdata_reg;
    logic                           m_tuser_reg;
    logic                           m_tlast_reg;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    assign item_pop = (state_reg == ST_IDLE) && item_valid;
    assign out_free = !m_tvalid_reg || m_tready;

    // Four restoring steps per cycle on each center lane; the remainder stays
    // below the grid count, so every step is a narrow compare and subtract.
    always_comb
    begin
        logic [GRID_W-1:0] rem_v;
        logic [DVD_W-1:0]  dvd_v;
        logic [GRID_W:0]   t_v;
        for (int l = 0; l < LANES; l++)
        begin
            rem_v = rem_reg[l];
            dvd_v = dvd_reg[l];
            for (int k = 0; k < DIV_RADIX_BITS; k++)
            begin
                t_v   = {rem_v, dvd_v[DVD_W-1]};
                dvd_v = {dvd_v[DVD_W-2:0], 1'b0};
                if (t_v >= {1'b0, div_reg})
                begin
                    rem_v    = GRID_W'(t_v - {1'b0, div_reg});
                    dvd_v[0] = 1'b1;
                end
                else
                begin
                    rem_v = t_v[GRID_W-1:0];
                end
            end
            rem_next[l] = rem_v;
            dvd_next[l] = dvd_v;
        end
    end

    // Lanes: 0 predicted x, 1 predicted y, 2 target x, 3 target y.
    assign iw_next = overlap(center(dvd_reg[0], neg_reg[0]), item_reg.pred_w,
                             center(dvd_reg[2], neg_reg[2]), item_reg.tgt_w);
    assign ih_next = overlap(center(dvd_reg[1], neg_reg[1]), item_reg.pred_h,
                             center(dvd_reg[3], neg_reg[3]), item_reg.tgt_h);

    assign area_sum   = {area_p_reg[AREA_W-1], area_p_reg} + {area_t_reg[AREA_W-1], area_t_reg};
    assign inter_ext  = {{(UNI_W-INTER_W){1'b0}}, inter_reg};
    assign part_shift = {part_reg[UNI_W-2:0], 1'b0};

    // The first box of a cell always loads the tracker; later ties keep the older box.
    assign better         = (item_reg.idx == '0) || (iou_reg > best_iou_reg);
    assign new_best_iou   = better ? iou_reg : best_iou_reg;
    assign new_best_index = better ? item_reg.idx : best_index_reg;

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                item_reg <= item;
                div_reg  <= (grid_count == '0) ? GRID_W'(1) : grid_count;
                dvd_reg[0] <= {(item.pred_cx[COORD_W-1] ? -item.pred_cx : item.pred_cx),
                               {FRAC_W{1'b0}}};
                dvd_reg[1] <= {(item.pred_cy[COORD_W-1] ? -item.pred_cy : item.pred_cy),
                               {FRAC_W{1'b0}}};
                dvd_reg[2] <= {(item.tgt_cx[COORD_W-1] ? -item.tgt_cx : item.tgt_cx),
                               {FRAC_W{1'b0}}};
                dvd_reg[3] <= {(item.tgt_cy[COORD_W-1] ? -item.tgt_cy : item.tgt_cy),
                               {FRAC_W{1'b0}}};
                neg_reg <= {item.tgt_cy[COORD_W-1], item.tgt_cx[COORD_W-1],
                            item.pred_cy[COORD_W-1], item.pred_cx[COORD_W-1]};
                rem_reg <= '0;
            end
            ST_CDIV:
            begin
                dvd_reg <= dvd_next;
                rem_reg <= rem_next;
            end
            ST_CORN:
            begin
                iw_reg     <= iw_next;
                ih_reg     <= ih_next;
                area_p_reg <= item_reg.pred_w * item_reg.pred_h;
                area_t_reg <= item_reg.tgt_w * item_reg.tgt_h;
            end
            ST_MUL:
            begin
                inter_reg <= iw_reg * ih_reg;
            end
            ST_UNI:
            begin
                uni_reg <= $signed({{(UNI_W-AREA_SUM_W-AREA_SHIFT){area_sum[AREA_SUM_W-1]}},
                                    area_sum, {AREA_SHIFT{1'b0}}}) - $signed(inter_ext);
            end
            ST_CHK:
            begin
                part_reg <= inter_ext;
                quo_reg  <= '0;
                if (uni_reg <= 0)
                begin
                    iou_reg   <= '0;
                    degen_reg <= 1'b1;
                end
                else
                begin
                    iou_reg   <= IOU_ONE;
                    degen_reg <= 1'b0;
                end
            end
            ST_RATIO:
            begin
                if (part_shift >= $unsigned(uni_reg))
                begin
                    part_reg <= part_shift - $unsigned(uni_reg);
                    quo_reg  <= {quo_reg[IOU_FRAC-2:0], 1'b1};
                end
                else
                begin
                    part_reg <= part_shift;
                    quo_reg  <= {quo_reg[IOU_FRAC-2:0], 1'b0};
                end
                if (cnt_reg == CNT_W'(IOU_FRAC - 1))
                begin
                    iou_reg <= {1'b0, quo_reg[IOU_FRAC-2:0],
                                (part_shift >= $unsigned(uni_reg))};
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    m_tdata_reg <= {{(OUT_DATA_W-OUT_FIELDS_W){1'b0}}, new_best_index,
                                    new_best_iou, iou_reg};
                    m_tuser_reg <= degen_reg;
                    m_tlast_reg <= item_reg.done;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            m_tvalid_reg   <= 1'b0;
            best_iou_reg   <= '0;
            best_index_reg <= '0;
        end
        else
        begin
            if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    cnt_reg <= '0;
                    if (item_valid)
                    begin
                        state_reg <= ST_CDIV;
                    end
                end
                ST_CDIV:
                begin
                    if (cnt_reg == CNT_W'(DIV_CYCLES - 1))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= ST_CORN;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end
                ST_CORN:
                begin
                    state_reg <= ST_MUL;
                end
                ST_MUL:
                begin
                    state_reg <= ST_UNI;
                end
                ST_UNI:
                begin
                    state_reg <= ST_CHK;
                end
                ST_CHK:
                begin
                    cnt_reg <= '0;
                    // A degenerate union or a full overlap skips the divider; a full overlap saturates.
                    if ((uni_reg <= 0) || (inter_ext >= $unsigned(uni_reg)))
                    begin
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        state_reg <= ST_RATIO;
                    end
                end
                ST_RATIO:
                begin
                    if (cnt_reg == CNT_W'(IOU_FRAC - 1))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                        if (item_reg.done)
                        begin
                            best_iou_reg   <= '0;
                            best_index_reg <= '0;
                        end
                        else
                        begin
                            best_iou_reg   <= new_best_iou;
                            best_index_reg <= new_best_index;
                        end
                    end
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> design/box_iou_best_match.sv
// Channel   Direction  Ports                       Contents, lowest bit first
// config    in         cfg_we, cfg_wdata[6:0]      grid_count
// request   in         s_tvalid/s_tready/s_tdata   pred_cx, pred_cy, pred_w, pred_h,
//                      s_tlast                     tgt_cx, tgt_cy, tgt_w, tgt_h; last_box
// result    out        m_tvalid/m_tready/m_tdata   iou, best_iou, best_index, zero pad;
//                      m_tuser, m_tlast            degenerate; cell_done
//
// In the back end a request is loaded, the four center divisions run at four quotient
// bits a cycle, corners, products, union and the union check follow, then the
// one-bit-per-cycle IoU divider runs and the result goes to the output register once
// that is free. The back end holds one request at a time.
// Degenerate or fully overlapping pairs skip the IoU divider.
// A two-entry queue lets requests be taken while the back end works or a result stalls.
// Reset clears the tracker, the queue and the box position; grid_count resets to 7.
`default_nettype none

module box_iou_best_match (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               cfg_we,
    input  wire  [biou_pkg::GRID_W-1:0]       cfg_wdata,
    input  wire                               s_tvalid,
    output logic                              s_tready,
    // pred_cx, pred_cy, pred_w, pred_h, tgt_cx, tgt_cy, tgt_w, tgt_h
    input  wire  [biou_pkg::IN_DATA_W-1:0]    s_tdata,
    input  wire                               s_tlast,
    output logic                              m_tvalid,
    input  wire                               m_tready,
    // iou, best_iou, best_index, zero pad
    output logic [biou_pkg::OUT_DATA_W-1:0]   m_tdata,
    // degenerate
    output logic                              m_tuser,
    output logic                              m_tlast
);
    import biou_pkg::*;

    localparam logic [GRID_W-1:0] GRID_RESET = GRID_W'(7);

    logic [GRID_W-1:0] grid_count_reg;
    logic              q_full;
    logic              push;
    biou_item_t        push_item;
    logic              q_not_empty;
    logic              pop;
    biou_item_t        rd_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_count_reg <= GRID_RESET;
        end
        else if (cfg_we)
        begin
            grid_count_reg <= cfg_wdata;
        end
    end

    biou_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    biou_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .rd_item   (rd_item)
    );

    biou_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .grid_count (grid_count_reg),
        .item_valid (q_not_empty),
        .item       (rd_item),
        .item_pop   (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire

>>> sim/tb_box_iou_best_match.sv
module tb_box_iou_best_match;
    timeunit 1ns;
    timeprecision 1ps;

    import biou_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 40;
    localparam int LONG_HOLD     = 300;
    localparam int PHASE_ITEMS   = 160;
    localparam int DIRECTED_ROWS = 16;
    localparam int GRID_PHASES   = 6;

    localparam logic [GRID_W-1:0] GRID_PLAN [GRID_PHASES] = '{1, 64, 0, 127, 13, 7};

    typedef struct {
        logic [IOU_W-1:0]     iou;
        logic                 degenerate;
        logic [IOU_W-1:0]     best_iou;
        logic [BOX_IDX_W-1:0] best_index;
        logic                 cell_done;
    } match_result_t;

    // One directed request; iou and degen are only used when typed is set.
    typedef struct packed {
        logic [COORD_W-1:0] pcx, pcy, pw, ph, tcx, tcy, tw, th;
        logic               last;
        logic               typed;
        logic [IOU_W-1:0]   iou;
        logic               degen;
    } pair_row_t;

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [GRID_W-1:0]      cfg_wdata = '0;
    logic                   s_tvalid = 1'b0;
    wire                    s_tready;
    // pred_cx, pred_cy, pred_w, pred_h, tgt_cx, tgt_cy, tgt_w, tgt_h
    logic [IN_DATA_W-1:0]   s_tdata = '0;
    logic                   s_tlast = 1'b0;
    wire                    m_tvalid;
    logic                   m_tready = 1'b0;
    // iou, best_iou, best_index, zero pad
    wire  [OUT_DATA_W-1:0]  m_tdata;
    // degenerate
    wire                    m_tuser;
    wire                    m_tlast;

    logic [GRID_W-1:0]      grid_setting = 7;
    logic [IOU_W-1:0]       cell_best_iou = '0;
    logic [BOX_IDX_W-1:0]   cell_best_index = '0;
    logic [BOX_IDX_W-1:0]   cell_position = '0;

    match_result_t          expected_matches [$];
    pair_row_t              directed_rows [DIRECTED_ROWS];
    int                     mismatch_count = 0;
    int                     tx_idle_pct = 0;
    int                     rx_idle_pct = 0;
    int                     hold_left = 0;
    logic                   hold_request = 1'b0;

    box_iou_best_match u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic match_result_t predict_match(input logic [IN_DATA_W-1:0] data,
                                                    input logic last);
        match_result_t        r;
        longint               divisor;
        longint               ctr_p, half_p, ctr_t, half_t, span;
        longint               inter, area_p, area_t, uni, rem;
        longint               ov [2];
        longint               len_p [2];
        longint               len_t [2];
        logic [IOU_W-1:0]     ratio;
        logic [BOX_IDX_W-1:0] pos;
        divisor = (grid_setting == 0) ? 1 : longint'(grid_setting);
        for (int a = 0; a < 2; a++)
        begin
            ctr_p  = (longint'($signed(data[COORD_W*a +: COORD_W])) <<< FRAC_W) / divisor;
            half_p = longint'($signed(data[COORD_W*(a+2) +: COORD_W])) <<< HALF_SHIFT;
            ctr_t  = (longint'($signed(data[COORD_W*(a+4) +: COORD_W])) <<< FRAC_W) / divisor;
            half_t = longint'($signed(data[COORD_W*(a+6) +: COORD_W])) <<< HALF_SHIFT;
            span = ((ctr_p + half_p < ctr_t + half_t) ? ctr_p + half_p : ctr_t + half_t)
                 - ((ctr_p - half_p > ctr_t - half_t) ? ctr_p - half_p : ctr_t - half_t);
            ov[a]    = (span > 0) ? span : 0;
            len_p[a] = 2 * half_p;
            len_t[a] = 2 * half_t;
        end
        inter  = ov[0] * ov[1];
        area_p = len_p[0] * len_p[1];
        area_t = len_t[0] * len_t[1];
        uni    = area_p + area_t - inter;
        r.degenerate = (uni <= 0);
        if (uni <= 0)
            ratio = '0;
        else if (inter >= uni)
            ratio = IOU_ONE;
        else
        begin
            // Restoring division, one quotient bit per step.
            ratio = '0;
            rem = inter;
            repeat (IOU_FRAC)
            begin
                rem = rem << 1;
                ratio = ratio << 1;
                if (rem >= uni)
                begin
                    rem = rem - uni;
                    ratio[0] = 1'b1;
                end
            end
        end
        pos = cell_position;
        if (pos == 0 || ratio > cell_best_iou)
        begin
            cell_best_iou   = ratio;
            cell_best_index = pos;
        end
        r.iou        = ratio;
        r.best_iou   = cell_best_iou;
        r.best_index = cell_best_index;
        r.cell_done  = last || (pos >= BOXES_PER_CELL - 1);
        if (r.cell_done)
        begin
            cell_best_iou   = '0;
            cell_best_index = '0;
            cell_position   = '0;
        end
        else
            cell_position = pos + 1'b1;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t ns: %s got %0d expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic send_pair(input logic [IN_DATA_W-1:0] data, input logic last,
                             input logic typed, input logic [IOU_W-1:0] typed_iou,
                             input logic typed_degenerate);
        match_result_t r;
        if ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < tx_idle_pct)
                @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        r = predict_match(data, last);
        if (typed)
        begin
            r.iou        = typed_iou;
            r.degenerate = typed_degenerate;
        end
        expected_matches.push_back(r);
    endtask

    task automatic wait_for_results;
        s_tvalid <= 1'b0;
        while (expected_matches.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_grid(input logic [GRID_W-1:0] value);
        wait_for_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        grid_setting = value;
    endtask

    initial
    begin
        logic [COORD_W-1:0] field [8];
        int                 pick;
        logic               last;
        directed_rows = '{
            // identical boxes right after reset
            '{16'h0800, 16'h0800, 16'h0400, 16'h0400, 16'h0800, 16'h0800, 16'h0400, 16'h0400,
              1'b0, 1'b1, 16'h8000, 1'b0},
            // disjoint boxes, and the cell closes on the full count
            '{16'h0800, 16'h0800, 16'h0400, 16'h0400, 16'h7000, 16'h7000, 16'h0400, 16'h0400,
              1'b0, 1'b1, 16'h0000, 1'b0},
            '{16'h0800, 16'h0800, 16'h0000, 16'h0000, 16'h0800, 16'h0800, 16'h0000, 16'h0000,
              1'b1, 1'b1, 16'h0000, 1'b1},
            '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
              1'b0, 1'b1, 16'h0000, 1'b0},
            '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
              1'b0, 1'b1, 16'h8000, 1'b0},
            '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
              1'b1, 1'b0, 16'h0000, 1'b0},
            // negative width only: the union goes negative
            '{16'h0800, 16'h0800, 16'hF000, 16'h1000, 16'h0800, 16'h0800, 16'hF000, 16'h1000,
              1'b1, 1'b1, 16'h0000, 1'b1},
            // two boxes with equal overlap: the first one keeps the best slot
            '{16'h0800, 16'h0800, 16'h0200, 16'h0200, 16'h0800, 16'h0800, 16'h0400, 16'h0400,
              1'b0, 1'b1, 16'h2000, 1'b0},
            '{16'h0800, 16'h0800, 16'h0100, 16'h0400, 16'h0800, 16'h0800, 16'h0400, 16'h0400,
              1'b0, 1'b1, 16'h2000, 1'b0},
            // the second box beats the first
            '{16'h0800, 16'h0800, 16'h0400, 16'h0400, 16'h7000, 16'h7000, 16'h0400, 16'h0400,
              1'b0, 1'b1, 16'h0000, 1'b0},
            '{16'h0800, 16'h0800, 16'h0400, 16'h0400, 16'h0800, 16'h0800, 16'h0400, 16'h0400,
              1'b1, 1'b1, 16'h8000, 1'b0},
            '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0800, 16'h0800, 16'h0400, 16'h0400,
              1'b1, 1'b1, 16'h0000, 1'b0},
            '{16'hC000, 16'hC000, 16'h0800, 16'h0800, 16'hC400, 16'hC000, 16'h0800, 16'h0800,
              1'b0, 1'b0, 16'h0000, 1'b0},
            '{16'h1234, 16'h5678, 16'h0ABC, 16'h0DEF, 16'h1300, 16'h5600, 16'h0A00, 16'h0E00,
              1'b1, 1'b0, 16'h0000, 1'b0},
            '{16'h7FFF, 16'h8000, 16'h1000, 16'h1000, 16'h7FFF, 16'h8000, 16'h2000, 16'h0800,
              1'b0, 1'b0, 16'h0000, 1'b0},
            '{16'h8000, 16'h7FFF, 16'h7FFF, 16'h0001, 16'h8001, 16'h7FFE, 16'h7FFF, 16'h0001,
              1'b1, 1'b0, 16'h0000, 1'b0}
        };
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = 20;
        rx_idle_pct = 59;
        for (int i = 0; i < DIRECTED_ROWS; i++)
            send_pair({directed_rows[i].th, directed_rows[i].tw, directed_rows[i].tcy,
                       directed_rows[i].tcx, directed_rows[i].ph, directed_rows[i].pw,
                       directed_rows[i].pcy, directed_rows[i].pcx},
                      directed_rows[i].last, directed_rows[i].typed,
                      directed_rows[i].iou, directed_rows[i].degen);

        for (int ph = 0; ph < GRID_PHASES; ph++)
        begin
            set_grid(GRID_PLAN[ph]);
            tx_idle_pct = (ph < 2) ? 20 : (ph < 4) ? 59 : 0;
            rx_idle_pct = (ph < 2) ? 59 : (ph < 4) ? 20 : 0;
            // The receiver stalls long enough for the request side to back up.
            if (ph == 4)
                hold_request = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pick = $urandom_range(99);
                if (pick < 25)
                begin
                    for (int k = 0; k < 8; k++)
                        field[k] = 16'($urandom);
                end
                else
                begin
                    // Plausible boxes: target near the prediction with positive sizes.
                    field[0] = 16'($urandom_range(16'h6000) - 16'h3000);
                    field[1] = 16'($urandom_range(16'h6000) - 16'h3000);
                    field[2] = 16'($urandom_range(16'h2000, 16'h0010));
                    field[3] = 16'($urandom_range(16'h2000, 16'h0010));
                    if (pick < 32)
                    begin
                        for (int k = 0; k < 4; k++)
                            field[k+4] = field[k];
                    end
                    else
                    begin
                        field[4] = field[0] + 16'($urandom_range(16'h0800)) - 16'h0400;
                        field[5] = field[1] + 16'($urandom_range(16'h0800)) - 16'h0400;
                        field[6] = 16'($urandom_range(16'h2000, 16'h0010));
                        field[7] = 16'($urandom_range(16'h2000, 16'h0010));
                    end
                end
                last = ($urandom_range(99) < 35);
                send_pair({field[7], field[6], field[5], field[4],
                           field[3], field[2], field[1], field[0]},
                          last, 1'b0, '0, 1'b0);
            end
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_box_iou_best_match: clean");
        else
            $display("tb_box_iou_best_match: errors");
        $finish;
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = LONG_HOLD;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial
    begin
        match_result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                if (expected_matches.size() == 0)
                    report_mismatch("result with no request pending, iou", m_tdata[15:0], 0);
                else
                begin
                    want = expected_matches.pop_front();
                    if (m_tdata[IOU_W-1:0] !== want.iou)
                        report_mismatch("iou", m_tdata[IOU_W-1:0], want.iou);
                    if (m_tuser !== want.degenerate)
                        report_mismatch("degenerate", m_tuser, want.degenerate);
                    if (m_tdata[2*IOU_W-1:IOU_W] !== want.best_iou)
                        report_mismatch("best_iou", m_tdata[2*IOU_W-1:IOU_W], want.best_iou);
                    if (m_tdata[2*IOU_W +: BOX_IDX_W] !== want.best_index)
                        report_mismatch("best_index", m_tdata[2*IOU_W +: BOX_IDX_W],
                                        want.best_index);
                    if (m_tlast !== want.cell_done)
                        report_mismatch("cell_done", m_tlast, want.cell_done);
                end
            end
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("tb_box_iou_best_match: errors");
        $finish;
    end

endmodule
